>>> design/tcc_pkg.sv
package tcc_pkg;

    typedef enum logic [1:0] {
        OP_DRAW   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_SCROLL = 2'd2,
        OP_FAULT  = 2'd3
    } t_op;

    // configuration register indexes
    localparam logic [1:0] CFG_COLUMNS    = 2'd0;
    localparam logic [1:0] CFG_ROWS       = 2'd1;
    localparam logic [1:0] CFG_TEXT_COLOR = 2'd2;

    localparam logic [7:0]  COLUMNS_RESET    = 8'd80;
    localparam logic [7:0]  ROWS_RESET       = 8'd24;
    localparam logic [31:0] TEXT_COLOR_RESET = 32'hFFFF_FFFF;

    localparam logic [7:0] CHAR_PRINT_LO  = 8'h20;
    localparam logic [7:0] CHAR_PRINT_HI  = 8'h7E;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;

    // one queue word: the first command of a character, and whether a
    // scroll command follows it
    typedef struct packed {
        t_op         op;
        logic [7:0]  cell_column;
        logic [7:0]  cell_row;
        logic [7:0]  glyph_code;
        logic [31:0] glyph_color;
        logic        scroll_next;
    } t_entry;

    typedef struct packed {
        t_op         op;
        logic [7:0]  cell_column;
        logic [7:0]  cell_row;
        logic [7:0]  glyph_code;
        logic [31:0] glyph_color;
        logic        last;
    } t_result;

endpackage

>>> design/tcc_front.sv
module tcc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_char_code,
    input  logic [7:0]       i_columns,
    input  logic [7:0]       i_rows,
    input  logic [31:0]      i_text_color,
    output logic             o_wr,
    output tcc_pkg::t_entry  o_entry
);
    import tcc_pkg::*;

    logic [7:0] r_cursor_column, n_cursor_column;
    logic [7:0] r_cursor_row, n_cursor_row;
    logic       r_halted, n_halted;

    logic [7:0] ncol, nrow;
    logic [8:0] col9, row9;
    logic       has_first, scroll, fault;
    t_entry     first;

    assign ncol = (i_columns == 8'd0) ? 8'd1 : i_columns;
    assign nrow = (i_rows == 8'd0) ? 8'd1 : i_rows;

    always_comb begin
        col9      = {1'b0, r_cursor_column};
        row9      = {1'b0, r_cursor_row};
        has_first = 1'b0;
        scroll    = 1'b0;
        fault     = 1'b0;
        first     = '0;
        first.op  = OP_DRAW;

        if (i_char_code >= CHAR_PRINT_LO && i_char_code <= CHAR_PRINT_HI) begin
            has_first         = 1'b1;
            first.op          = OP_DRAW;
            first.cell_column = r_cursor_column;
            first.cell_row    = r_cursor_row;
            first.glyph_code  = i_char_code;
            first.glyph_color = i_text_color;
            col9              = col9 + 9'd1;
        end else if (i_char_code == CHAR_NEWLINE) begin
            col9 = 9'd0;
            row9 = row9 + 9'd1;
        end else if (i_char_code == CHAR_BACKSPACE) begin
            if (r_cursor_column != 8'd0) begin
                has_first         = 1'b1;
                col9              = col9 - 9'd1;
                first.op          = OP_CLEAR;
                first.cell_column = col9[7:0];
                first.cell_row    = r_cursor_row;
            end
        end else begin
            fault = 1'b1;
        end

        // wrap past the last column, then scroll past the last row
        if (col9 >= {1'b0, ncol}) begin
            col9 = 9'd0;
            row9 = row9 + 9'd1;
        end
        if (row9 >= {1'b0, nrow}) begin
            scroll = 1'b1;
            row9   = {1'b0, nrow - 8'd1};
        end

        o_entry = '0;
        o_entry.op = OP_SCROLL;
        if (fault) begin
            o_entry.op = OP_FAULT;
        end else if (has_first) begin
            o_entry             = first;
            o_entry.scroll_next = scroll;
        end

        o_wr = i_accept && !r_halted && (fault || has_first || scroll);

        n_halted        = r_halted;
        n_cursor_column = r_cursor_column;
        n_cursor_row    = r_cursor_row;
        if (i_accept && !r_halted) begin
            if (fault) begin
                n_halted = 1'b1;
            end else begin
                n_cursor_column = col9[7:0];
                n_cursor_row    = row9[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_column <= '0;
            r_cursor_row    <= '0;
            r_halted        <= 1'b0;
        end else begin
            r_cursor_column <= n_cursor_column;
            r_cursor_row    <= n_cursor_row;
            r_halted        <= n_halted;
        end
    end

endmodule

>>> design/tcc_queue.sv
module tcc_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  tcc_pkg::t_entry  i_entry,
    output logic             o_full,
    input  logic             i_rd,
    output tcc_pkg::t_entry  o_entry,
    output logic             o_empty
);
    import tcc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_wr, do_rd;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> design/tcc_back.sv
module tcc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcc_pkg::t_entry   i_entry,
    input  logic              i_q_empty,
    output logic              o_q_rd,
    output tcc_pkg::t_result  o_result,
    output logic              o_valid,
    input  logic              i_take
);
    import tcc_pkg::*;

    t_result r_result;
    logic    r_valid;
    logic    r_pend_scroll;
    logic    advance;

    assign advance  = !r_valid || i_take;
    assign o_q_rd   = advance && !r_pend_scroll && !i_q_empty;
    assign o_result = r_result;
    assign o_valid  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_pend_scroll <= 1'b0;
        end else if (advance) begin
            if (r_pend_scroll) begin
                r_valid       <= 1'b1;
                r_pend_scroll <= 1'b0;
            end else begin
                r_valid       <= !i_q_empty;
                r_pend_scroll <= !i_q_empty && i_entry.scroll_next;
            end
        end
    end

    // payload: second half of a pair is always a bare scroll
    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (r_pend_scroll) begin
                r_result.op          <= OP_SCROLL;
                r_result.cell_column <= '0;
                r_result.cell_row    <= '0;
                r_result.glyph_code  <= '0;
                r_result.glyph_color <= '0;
                r_result.last        <= 1'b1;
            end else begin
                r_result.op          <= i_entry.op;
                r_result.cell_column <= i_entry.cell_column;
                r_result.cell_row    <= i_entry.cell_row;
                r_result.glyph_code  <= i_entry.glyph_code;
                r_result.glyph_color <= i_entry.glyph_color;
                r_result.last        <= !i_entry.scroll_next;
            end
        end
    end

endmodule

>>> design/text_console_cursor_controller.sv
// Text console cursor controller: takes one character byte per word on the
// push side and returns cell commands (draw glyph, clear cell, scroll one row,
// fault) on the pop side, each marked last on the final command of its
// character. It accepts one character every cycle while full is low; the
// front classifies the character and moves the cursor in that same cycle.
// Commands leave at one per cycle while pop is high, so a character that
// yields two commands (draw or clear followed by scroll) holds the output for
// both, and a run of those is absorbed by the QUEUE_DEPTH-word queue before
// full rises. The first command of a character is written into the queue when
// its push is accepted and registered in the back stage before it shows on
// the pop side. Characters that yield nothing (a newline without scroll,
// backspace at column zero, anything after a fault) are accepted too. After a
// fault every character is swallowed until reset. Configuration writes are
// taken every cycle (ready stays high) and must only be issued while idle.
module text_console_cursor_controller #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_code,
    // command side
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_op,
    output logic [7:0]  o_cell_column,
    output logic [7:0]  o_cell_row,
    output logic [7:0]  o_glyph_code,
    output logic [31:0] o_glyph_color,
    output logic        o_last,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import tcc_pkg::*;

    logic [7:0]  r_columns;
    logic [7:0]  r_rows;
    logic [31:0] r_text_color;

    logic    accept;
    logic    q_wr, q_rd, q_full, q_empty;
    t_entry  wr_entry, rd_entry;
    t_result result;
    logic    out_valid;

    assign o_cfg_ready = 1'b1;

    // hold geometry and color; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns    <= COLUMNS_RESET;
            r_rows       <= ROWS_RESET;
            r_text_color <= TEXT_COLOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_COLUMNS:    r_columns    <= i_cfg_data[7:0];
                CFG_ROWS:       r_rows       <= i_cfg_data[7:0];
                CFG_TEXT_COLOR: r_text_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the queue's own full gates input; the front writes at most one word
    assign full   = q_full;
    assign accept = push && !q_full;

    tcc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_char_code  (i_char_code),
        .i_columns    (r_columns),
        .i_rows       (r_rows),
        .i_text_color (r_text_color),
        .o_wr         (q_wr),
        .o_entry      (wr_entry)
    );

    tcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_entry (wr_entry),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_entry (rd_entry),
        .o_empty (q_empty)
    );

    tcc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_entry   (rd_entry),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .o_result  (result),
        .o_valid   (out_valid),
        .i_take    (pop)
    );

    assign empty         = !out_valid;
    assign o_op          = result.op;
    assign o_cell_column = result.cell_column;
    assign o_cell_row    = result.cell_row;
    assign o_glyph_code  = result.glyph_code;
    assign o_glyph_color = result.glyph_color;
    assign o_last        = result.last;

`ifndef SYNTHESIS
    // a command that is not last is always followed at once by its scroll
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last) |=> (!empty && o_op == OP_SCROLL && o_last))
        else $error("second command of a pair missing");

    // scroll and fault always close their character
    a_closing_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_op == OP_SCROLL || o_op == OP_FAULT)) |-> o_last)
        else $error("scroll or fault not marked last");

    // only a draw or a clear can open a pair
    a_pair_opener: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last) |-> (o_op == OP_DRAW || o_op == OP_CLEAR))
        else $error("unexpected command opens a pair");
`endif

endmodule
